[rtl/grq_pkg.sv]
// ----------------------------------------------------------------------------
// Graph reachability query package
// Item types, field widths, operation and status codes shared by the block
// and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package grq_pkg;

	// Width of a node index field and of a link counter.
	localparam int NODE_W = 5;
	localparam int DEG_W  = 5;

	// Default sizing of the graph.
	localparam int NODE_COUNT_DEF = 32;
	localparam int MAX_DEGREE_DEF = 25;

	// Operation codes.
	localparam logic OP_CONNECT = 1'b0;
	localparam logic OP_QUERY   = 1'b1;

	// Status codes.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} request_t;

	typedef struct packed {
		logic connected;
		logic status;
	} result_t;

endpackage

`default_nettype wire

[rtl/graph_reachability_query_top.sv]
// ----------------------------------------------------------------------------
// Graph reachability query
// Undirected graph held as an adjacency matrix with link counters; adds
// edges and answers reachability queries by a row-at-a-time search.
// ----------------------------------------------------------------------------
// A connect item reads row a, then row b, then checks and, if the link fits, writes row a,
// and row b in a further state when two distinct rows are written, before its result
// strobe. A query reads the start row and one row per reached node, one row read a cycle.
// One item at a time; the next is accepted at the earliest at the edge that ends the
// result strobe.
// Reset clears all rows at once through per-row valid bits; the receiver cannot stall.
`default_nettype none

module graph_reachability_query_top
	import grq_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire request_t request,
	output logic          done,
	output result_t       result
);

	// Address width of the row memory and width of one stored word. Each word
	// holds a node's link counter above its adjacency row.
	localparam int AW     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int WORD_W = NODE_COUNT + DEG_W;
	localparam logic [NODE_W+1:0] NODE_LIMIT = (NODE_W+2)'(NODE_COUNT);
	localparam logic [DEG_W:0]    DEG_LIMIT  = (DEG_W+1)'(MAX_DEGREE);
	localparam logic [NODE_COUNT-1:0] ONE_HOT0 = NODE_COUNT'(1);

	// Sequencer states. A connect reads row a, then row b, then decides and, if the link
	// fits, writes row a, and row b in a further cycle when it is a different node.
	// A query reads one row a cycle in the search state.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CONB  = 3'd1;
	localparam logic [2:0] S_CONCK = 3'd2;
	localparam logic [2:0] S_CONWB = 3'd3;
	localparam logic [2:0] S_QRUN  = 3'd4;

	// Lowest set bit of a row: the next node to expand in a query.
	function automatic logic [AW-1:0] lowest_node(input logic [NODE_COUNT-1:0] v);
		logic [AW-1:0] idx;
		idx = '0;
		for (int i = NODE_COUNT - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = AW'(i);
			end
		end
		return idx;
	endfunction

	logic [2:0]            state_q;
	logic [NODE_W-1:0]     node_a_q;
	logic [NODE_W-1:0]     node_b_q;
	logic                  range_ok_q;
	logic [NODE_COUNT-1:0] row_a_q;
	logic [DEG_W-1:0]      deg_a_q;
	logic [NODE_COUNT-1:0] row_b_q;
	logic [DEG_W-1:0]      deg_b_q;
	logic [NODE_COUNT-1:0] visited_q;
	logic [NODE_COUNT-1:0] frontier_q;
	logic                  done_q;
	result_t               result_q;

	// Row memory, its per-row valid bits and the registered read port.
	logic [WORD_W-1:0]     mem [NODE_COUNT];
	logic [NODE_COUNT-1:0] row_valid_q;
	logic [WORD_W-1:0]     rd_word_s1;
	logic                  rd_vld_s1;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [WORD_W-1:0]     wr_word;

	logic                  accept;
	logic                  in_range;
	logic [AW-1:0]         idx_a;
	logic [AW-1:0]         idx_b;
	logic                  same_node;
	logic [NODE_COUNT-1:0] bit_a;
	logic [NODE_COUNT-1:0] bit_b;
	logic [NODE_COUNT-1:0] rd_row;
	logic [DEG_W-1:0]      rd_deg;
	logic [DEG_W:0]        deg_a_sum;
	logic                  link_ok;
	logic [NODE_COUNT-1:0] fresh;
	logic [NODE_COUNT-1:0] visited_nx;
	logic [NODE_COUNT-1:0] frontier_nx;
	logic [AW-1:0]         next_node;
	logic                  search_end;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Both indices must name a node that exists; the fields are wider than
	// the address when the graph is small.
	assign in_range = ({2'b00, request.node_a} < NODE_LIMIT)
	               && ({2'b00, request.node_b} < NODE_LIMIT);

	assign idx_a     = AW'(node_a_q);
	assign idx_b     = AW'(node_b_q);
	assign same_node = (node_a_q == node_b_q);
	assign bit_a     = ONE_HOT0 << idx_a;
	assign bit_b     = ONE_HOT0 << idx_b;

	// A row that has never been written reads as empty with no links.
	assign rd_row = rd_vld_s1 ? rd_word_s1[NODE_COUNT-1:0] : '0;
	assign rd_deg = rd_vld_s1 ? rd_word_s1[WORD_W-1:NODE_COUNT] : '0;

	// Connect check, made while row b arrives. A self-loop needs two free
	// links on the one node; otherwise each side needs one.
	assign deg_a_sum = {1'b0, deg_a_q} + (same_node ? (DEG_W+1)'(2) : (DEG_W+1)'(1));
	assign link_ok   = range_ok_q && (deg_a_sum <= DEG_LIMIT)
	                && ({1'b0, rd_deg} < DEG_LIMIT);

	// Search step: the row read last cycle adds any unreached neighbours to
	// both the reached set and the set still to expand. Since a node enters
	// the frontier only once, the search ends within NODE_COUNT + 1 row reads, the start row included.
	assign fresh       = rd_row & ~visited_q;
	assign visited_nx  = visited_q | fresh;
	assign frontier_nx = frontier_q | fresh;
	assign next_node   = lowest_node(frontier_nx);
	assign search_end  = !range_ok_q || (frontier_nx == '0);

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_b;
		wr_en   = 1'b0;
		wr_addr = idx_a;
		wr_word = {deg_a_sum[DEG_W-1:0], row_a_q | bit_b};
		case (state_q)
			S_IDLE: begin
				rd_en   = accept;
				rd_addr = AW'(request.node_a);
			end
			S_CONB: begin
				rd_en   = 1'b1;
				rd_addr = idx_b;
			end
			S_CONCK: begin
				wr_en = link_ok;
			end
			S_CONWB: begin
				wr_en   = 1'b1;
				wr_addr = idx_b;
				wr_word = {deg_b_q + DEG_W'(1), row_b_q | bit_a};
			end
			S_QRUN: begin
				rd_en   = !search_end;
				rd_addr = next_node;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_word_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= row_valid_q[rd_addr];
			end
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (request.operation == OP_QUERY) ? S_QRUN : S_CONB;
					end
				end
				S_CONB: begin
					state_q <= S_CONCK;
				end
				S_CONCK: begin
					if (link_ok && !same_node) begin
						state_q <= S_CONWB;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_CONWB: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_QRUN: begin
					if (search_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload and working rows.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					node_a_q   <= request.node_a;
					node_b_q   <= request.node_b;
					range_ok_q <= in_range;
					// The reached set starts empty in every query.
					visited_q  <= '0;
					frontier_q <= '0;
				end
			end
			S_CONB: begin
				row_a_q <= rd_row;
				deg_a_q <= rd_deg;
			end
			S_CONCK: begin
				row_b_q <= rd_row;
				deg_b_q <= rd_deg;
				result_q.connected <= 1'b0;
				result_q.status    <= link_ok ? STATUS_OK : STATUS_FULL;
			end
			S_QRUN: begin
				visited_q  <= visited_nx;
				frontier_q <= frontier_nx & ~(ONE_HOT0 << next_node);
				result_q.connected <= range_ok_q && visited_nx[idx_b];
				result_q.status    <= STATUS_OK;
			end
			default: begin
				visited_q <= visited_q;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/grq_checker.sv]
// ----------------------------------------------------------------------------
// Graph reachability query checker
// Watches the top-level ports for the command and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module grq_checker
	import grq_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire request_t request,
	input wire logic     done,
	input wire result_t  result
);

	// An accepted item always raises busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// A result is only shown once the work has finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// Every result closes a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// One result per item: strobes never come back to back.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// A refused connect never also reports reachability.
	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.connected && (result.status == STATUS_FULL)))
		else $error("result reports both connected and refused");

endmodule

bind graph_reachability_query_top grq_checker u_grq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

`default_nettype wire
